/* rtl/hre_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hre_pkg: shared types and constants of the hex record encoder
// Holds the format codes, register indexes, character codes and the job
// descriptor that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package hre_pkg;

   // record formats, as held after decoding the format register
   typedef enum logic [1:0] {
      FMT_SREC  = 2'd0,
      FMT_INTEL = 2'd1,
      FMT_TEK   = 2'd2
   } fmt_type;

   // configuration register indexes
   localparam int        CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 1'b1;

   // largest byte count an S2 record can carry
   localparam logic [7:0] S_MAX_COUNT = 8'd251;

   // characters
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_S       = 8'h53;
   localparam logic [7:0] CH_TWO     = 8'h32;
   localparam logic [7:0] CH_EIGHT   = 8'h38;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;

   // one decoded item: everything the back end needs to emit its characters
   typedef struct packed {
      fmt_type     fmt;
      logic        term;     // end record
      logic        has_hdr;  // record header comes first
      logic        has_trl;  // checksum and newline close the record
      logic        err;
      logic [7:0]  data;
      logic [7:0]  count;    // effective count, zero for end records
      logic [23:0] addr;     // address as printed
   } job_type;

   // uppercase hex digit of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h37 + {4'h0, nib};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/hre_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hre_front: item intake and classification
// Holds the configuration registers, the running address and the count of
// bytes left in the record; turns each accepted item into a job descriptor.
// ----------------------------------------------------------------------------
module hre_front
   import hre_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   // items in
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_kind,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic [7:0]           req_record_count,
   // jobs out
   input  wire logic                 queue_full,
   output      logic                 push,
   output      job_type              push_job
);

   fmt_type     format_ff;
   logic [31:0] offset_ff;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  remain_ff, remain_in;

   logic        rem_zero;
   logic [7:0]  cnt_eff;
   logic        cnt_err;
   logic [31:0] s_addr;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      rem_zero = (remain_ff == 8'd0);
      cnt_eff  = (req_record_count == 8'd0) ? 8'd1 : req_record_count;
      cnt_err  = (req_record_count == 8'd0) ||
                 ((format_ff == FMT_SREC) && (cnt_eff > S_MAX_COUNT));
      s_addr   = addr_ff + offset_ff;

      push_job.fmt = format_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;

      if (req_kind) begin
         push_job.term    = 1'b1;
         push_job.has_hdr = 1'b1;
         push_job.has_trl = 1'b0;
         push_job.err     = !rem_zero;
         push_job.data    = 8'h00;
         push_job.count   = 8'h00;
         push_job.addr    = (format_ff == FMT_SREC) ? offset_ff[23:0] : 24'h0;
         addr_in          = 32'h0;
         remain_in        = 8'h00;
      end else begin
         push_job.term    = 1'b0;
         push_job.has_hdr = rem_zero;
         push_job.has_trl = rem_zero ? (cnt_eff == 8'd1) : (remain_ff == 8'd1);
         push_job.err     = rem_zero && cnt_err;
         push_job.data    = req_data_byte;
         push_job.count   = cnt_eff;
         push_job.addr    = (format_ff == FMT_SREC) ? s_addr[23:0]
                                                    : {8'h00, addr_ff[15:0]};
         if (rem_zero) begin
            addr_in   = addr_ff + {24'h0, cnt_eff};
            remain_in = cnt_eff - 8'd1;
         end else begin
            remain_in = remain_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_SREC;
         offset_ff <= 32'h0;
         addr_ff   <= 32'h0;
         remain_ff <= 8'h00;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_FORMAT) begin
               if (csr_wdata[1:0] == FMT_SREC) begin
                  format_ff <= FMT_SREC;
               end else if (csr_wdata[1:0] == FMT_INTEL) begin
                  format_ff <= FMT_INTEL;
               end else begin
                  format_ff <= FMT_TEK;
               end
            end else begin
               offset_ff <= csr_wdata;
            end
         end
         if (push) begin
            addr_ff   <= addr_in;
            remain_ff <= remain_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/hre_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hre_queue: job queue between front and back end
// A small circular buffer of job descriptors.
// ----------------------------------------------------------------------------
module hre_queue
   import hre_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output      logic    full,
   input  wire logic    pop,
   output      logic    head_valid,
   output      job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

endmodule

`default_nettype wire

/* rtl/hre_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hre_back: character sequencer
// Walks one job at a time through prefix, header pairs, data pair, trailer
// pair and newline, one character per cycle unless stalled; keeps the checksum.
// ----------------------------------------------------------------------------
module hre_back
   import hre_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire job_type    head_job,
   output      logic       pop,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_ascii_char,
   output      logic       rsp_run_last,
   output      logic       rsp_error
);

   typedef enum logic [4:0] {
      PH_PRE = 5'b00001,
      PH_HDR = 5'b00010,
      PH_DAT = 5'b00100,
      PH_TRL = 5'b01000,
      PH_NL  = 5'b10000
   } phase_type;

   logic       cur_valid_ff, cur_valid_in;
   job_type    cur_ff, cur_in;
   phase_type  phase_ff, phase_in;
   logic       digit_ff, digit_in;
   logic [1:0] pair_ff, pair_in;
   logic [7:0] cs_ff, cs_in;
   logic       rsp_valid_ff;
   logic [7:0] char_ff;
   logic       last_ff, err_ff;

   logic       out_free, advance, is_last;
   logic [7:0] pair_byte, char_now, contrib;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_error      = err_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = cur_valid_ff && out_free;

   // byte shown by the current pair
   always_comb begin
      pair_byte = 8'h00;
      case (phase_ff)
         PH_HDR: begin
            case (cur_ff.fmt)
               FMT_SREC: begin
                  case (pair_ff)
                     2'd0:    pair_byte = cur_ff.count + 8'd4;
                     2'd1:    pair_byte = cur_ff.addr[23:16];
                     2'd2:    pair_byte = cur_ff.addr[15:8];
                     default: pair_byte = cur_ff.addr[7:0];
                  endcase
               end
               FMT_INTEL: begin
                  case (pair_ff)
                     2'd0:    pair_byte = cur_ff.count;
                     2'd1:    pair_byte = cur_ff.addr[15:8];
                     2'd2:    pair_byte = cur_ff.addr[7:0];
                     default: pair_byte = {7'h00, cur_ff.term};
                  endcase
               end
               default: begin
                  case (pair_ff)
                     2'd0:    pair_byte = cur_ff.addr[15:8];
                     2'd1:    pair_byte = cur_ff.addr[7:0];
                     2'd2:    pair_byte = cur_ff.count;
                     default: pair_byte = cur_ff.term ? 8'h00 : cs_ff;
                  endcase
               end
            endcase
         end
         PH_DAT: begin
            if (!cur_ff.term) begin
               pair_byte = cur_ff.data;
            end else if (cur_ff.fmt == FMT_SREC) begin
               pair_byte = ~cs_ff;
            end else begin
               pair_byte = 8'hFF;
            end
         end
         PH_TRL: begin
            case (cur_ff.fmt)
               FMT_SREC:  pair_byte = ~cs_ff;
               FMT_INTEL: pair_byte = 8'h00 - cs_ff;
               default:   pair_byte = cs_ff;
            endcase
         end
         default: pair_byte = 8'h00;
      endcase
   end

   // character, last flag and checksum contribution
   always_comb begin
      case (phase_ff)
         PH_PRE: begin
            case (cur_ff.fmt)
               FMT_SREC:  char_now = !digit_ff ? CH_S :
                                     (cur_ff.term ? CH_EIGHT : CH_TWO);
               FMT_INTEL: char_now = CH_COLON;
               default:   char_now = CH_SLASH;
            endcase
         end
         PH_HDR, PH_DAT, PH_TRL: begin
            char_now = digit_ff ? hex_char(pair_byte[3:0]) : hex_char(pair_byte[7:4]);
         end
         default: char_now = CH_NEWLINE;
      endcase

      is_last = (phase_ff == PH_NL) ||
                ((phase_ff == PH_DAT) && digit_ff && !cur_ff.term && !cur_ff.has_trl);

      if (cur_ff.fmt == FMT_TEK) begin
         contrib = {4'h0, pair_byte[7:4]} + {4'h0, pair_byte[3:0]};
      end else begin
         contrib = pair_byte;
      end
   end

   // sequencing
   always_comb begin
      phase_in     = phase_ff;
      digit_in     = digit_ff;
      pair_in      = pair_ff;
      cs_in        = cs_ff;
      pop          = head_valid && (!cur_valid_ff || (advance && is_last));
      cur_in       = pop ? head_job : cur_ff;
      cur_valid_in = cur_valid_ff;

      if (advance) begin
         case (phase_ff)
            PH_PRE: begin
               if ((cur_ff.fmt == FMT_SREC) && !digit_ff) begin
                  digit_in = 1'b1;
               end else begin
                  phase_in = PH_HDR;
                  digit_in = 1'b0;
                  pair_in  = 2'd0;
               end
            end
            PH_HDR: begin
               if (!digit_ff) begin
                  digit_in = 1'b1;
               end else begin
                  digit_in = 1'b0;
                  // Tek header check restarts the sum for the data
                  if ((cur_ff.fmt == FMT_TEK) && (pair_ff == 2'd3)) begin
                     cs_in = 8'h00;
                  end else begin
                     cs_in = cs_ff + contrib;
                  end
                  if (pair_ff == 2'd3) begin
                     phase_in = ((cur_ff.fmt == FMT_TEK) && cur_ff.term) ? PH_NL : PH_DAT;
                  end else begin
                     pair_in = pair_ff + 2'd1;
                  end
               end
            end
            PH_DAT: begin
               if (!digit_ff) begin
                  digit_in = 1'b1;
               end else begin
                  digit_in = 1'b0;
                  cs_in    = cs_ff + contrib;
                  if (cur_ff.term) begin
                     phase_in = PH_NL;
                  end else if (cur_ff.has_trl) begin
                     phase_in = PH_TRL;
                  end
               end
            end
            PH_TRL: begin
               if (!digit_ff) begin
                  digit_in = 1'b1;
               end else begin
                  digit_in = 1'b0;
                  phase_in = PH_NL;
               end
            end
            PH_NL: begin
               cs_in = 8'h00;
            end
            default: phase_in = PH_PRE;
         endcase
         if (is_last) begin
            cur_valid_in = 1'b0;
         end
      end

      // load the next job
      if (pop) begin
         cur_valid_in = 1'b1;
         phase_in     = head_job.has_hdr ? PH_PRE : PH_DAT;
         digit_in     = 1'b0;
         pair_in      = 2'd0;
         if (head_job.has_hdr) begin
            cs_in = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         char_ff <= char_now;
         last_ff <= is_last;
         err_ff  <= cur_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= PH_PRE;
         digit_ff     <= 1'b0;
         pair_ff      <= 2'd0;
         cs_ff        <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         digit_ff     <= digit_in;
         pair_ff      <= pair_in;
         cs_ff        <= cs_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/hex_record_encoder_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_encoder_top: ASCII hex record encoder
// Encodes image bytes as Motorola S2/S8, Intel hex or Tek-hex records, one
// character per result item.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_kind, req_data_byte,
//                                             req_record_count
//   rsp_      out        rsp_valid/rsp_stall  rsp_ascii_char, rsp_run_last,
//                                             rsp_error
//   csr_      in         csr_write_en         csr_index, csr_wdata
//
// The back-end sequencer emits one character per cycle unless rsp_stall holds
// it; an item produces 2 characters for a byte inside a record, up to
// 15 for a byte that opens and closes a record, 10 to 13 for an end record.
// The front end takes an item per cycle while the job queue (QUEUE_DEPTH
// entries) has room; req_stall is high only when the queue is full.
// Reset is synchronous; it clears the format to S-record, the offset, the
// running address and the queue and sequencer control. No clearing pass.
// rsp_stall holds the output register; the sequencer and then the queue fill
// behind it before the input side sees a stall.
//
module hex_record_encoder_top
   import hre_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   // items in
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_kind,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic [7:0]           req_record_count,
   // characters out
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [7:0]           rsp_ascii_char,
   output      logic                 rsp_run_last,
   output      logic                 rsp_error
);

   // front to queue
   logic    push;
   job_type push_job;
   logic    queue_full;
   // queue to back
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // classify items, track address and record position
   hre_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_data_byte    (req_data_byte),
      .req_record_count (req_record_count),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   // decouple intake from character output
   hre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // emit characters, keep the checksum
   hre_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_error      (rsp_error)
   );

endmodule

`default_nettype wire

/* tb/hre_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_tb_pkg: character-level scoreboard of the hex record encoder
// Predicts the characters each accepted item produces (record header, hex
// digits, checksum trailer, end records) and checks the block's output
// characters in order against that prediction.
// ----------------------------------------------------------------------------
package hre_tb_pkg;
   import hre_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       err;
   } char_item;

   class record_text_model;
      logic [1:0]  format_reg;
      logic [31:0] offset_reg;
      logic [31:0] run_addr;
      logic [7:0]  left;
      logic [7:0]  csum;
      char_item    pending_chars[$];
      char_item    burst[$];
      int          mismatches;

      function new();
         format_reg = 2'd0;
         offset_reg = 32'd0;
         run_addr   = 32'd0;
         left       = 8'd0;
         csum       = 8'd0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         if (idx == CSR_FORMAT) begin
            format_reg = val[1:0];
         end else if (idx == CSR_OFFSET) begin
            offset_reg = val;
         end
      endfunction

      function logic [7:0] digit(logic [3:0] n);
         string digits;
         digits = "0123456789ABCDEF";
         return digits[n];
      endfunction

      function void emit(logic [7:0] c);
         char_item it;
         it.ch   = c;
         it.last = 1'b0;
         it.err  = 1'b0;
         burst.push_back(it);
      endfunction

      // two digits, checksum takes the whole byte
      function void emit_byte(logic [7:0] v);
         emit(digit(v[7:4]));
         emit(digit(v[3:0]));
         csum = csum + v;
      endfunction

      // two digits, checksum takes both nibbles
      function void emit_nibs(logic [7:0] v);
         emit(digit(v[7:4]));
         emit(digit(v[3:0]));
         csum = csum + {4'h0, v[7:4]} + {4'h0, v[3:0]};
      endfunction

      function void emit_text(string s);
         for (int i = 0; i < s.len(); i++) begin
            emit(s[i]);
         end
      endfunction

      function void encode_item(logic kind, logic [7:0] data, logic [7:0] count);
         fmt_type     fmt;
         logic        err;
         logic [7:0]  cnt;
         logic [31:0] start_addr;
         logic [23:0] a;
         logic [7:0]  sum_hold;
         fmt = (format_reg == 2'd3) ? FMT_TEK : fmt_type'(format_reg);
         err = 1'b0;
         cnt = count;
         burst.delete();
         if (kind) begin
            // end record; an open record is dropped without trailer
            err = (left != 8'd0);
            case (fmt)
               FMT_SREC: begin
                  a = offset_reg[23:0];
                  emit(CH_S);
                  emit(CH_EIGHT);
                  csum = 8'd0;
                  emit_byte(8'h04);
                  emit_byte(a[23:16]);
                  emit_byte(a[15:8]);
                  emit_byte(a[7:0]);
                  emit_byte(~csum);
                  emit(CH_NEWLINE);
               end
               FMT_INTEL: emit_text(":00000001FF\n");
               default:   emit_text("/00000000\n");
            endcase
            run_addr = 32'd0;
            left     = 8'd0;
            csum     = 8'd0;
         end else begin
            if (left == 8'd0) begin
               start_addr = run_addr;
               if (cnt == 8'd0) begin
                  err = 1'b1;
                  cnt = 8'd1;
               end
               if (fmt == FMT_SREC && cnt > S_MAX_COUNT) begin
                  err = 1'b1;
               end
               run_addr = run_addr + {24'd0, cnt};
               left     = cnt;
               csum     = 8'd0;
               case (fmt)
                  FMT_SREC: begin
                     a = offset_reg[23:0] + start_addr[23:0];
                     emit(CH_S);
                     emit(CH_TWO);
                     emit_byte(cnt + 8'd4);
                     emit_byte(a[23:16]);
                     emit_byte(a[15:8]);
                     emit_byte(a[7:0]);
                  end
                  FMT_INTEL: begin
                     emit(CH_COLON);
                     emit_byte(cnt);
                     emit_byte(start_addr[15:8]);
                     emit_byte(start_addr[7:0]);
                     emit_byte(8'h00);
                  end
                  default: begin
                     emit(CH_SLASH);
                     emit_nibs(start_addr[15:8]);
                     emit_nibs(start_addr[7:0]);
                     emit_nibs(cnt);
                     emit_nibs(csum);
                     csum = 8'd0;
                  end
               endcase
            end
            if (fmt == FMT_TEK) begin
               emit_nibs(data);
            end else begin
               emit_byte(data);
            end
            left = left - 8'd1;
            if (left == 8'd0) begin
               sum_hold = csum;
               case (fmt)
                  FMT_SREC:  emit_byte(~sum_hold);
                  FMT_INTEL: emit_byte(8'h00 - sum_hold);
                  default:   emit_nibs(sum_hold);
               endcase
               emit(CH_NEWLINE);
               csum = 8'd0;
            end
         end
         foreach (burst[i]) begin
            burst[i].last = (i == burst.size() - 1);
            burst[i].err  = err;
            pending_chars.push_back(burst[i]);
         end
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s", $time, msg);
         end
      endfunction

      function void match_char(logic [7:0] ch, logic last, logic err);
         char_item want;
         if (pending_chars.size() == 0) begin
            note_mismatch($sformatf("character 0x%02h with nothing pending", ch));
            return;
         end
         want = pending_chars.pop_front();
         if (want.ch !== ch) begin
            note_mismatch($sformatf("char expected 0x%02h got 0x%02h", want.ch, ch));
         end
         if (want.last !== last) begin
            note_mismatch($sformatf("run_last expected %b got %b (char 0x%02h)",
                                    want.last, last, want.ch));
         end
         if (want.err !== err) begin
            note_mismatch($sformatf("error expected %b got %b (char 0x%02h)",
                                    want.err, err, want.ch));
         end
      endfunction
   endclass

endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench of the hex record encoder
// Drives directed records in every format (extreme bytes and offsets, zero and
// long counts, end records inside and outside records, a format switch inside
// a record), then random record streams, with random idling on both sides.
// Every output character is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb;
   import hre_pkg::*;
   import hre_tb_pkg::*;

   // format code 3 is not decoded by the block; it must act as Tek-hex
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 450;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_kind;
   logic [7:0]           req_data_byte;
   logic [7:0]           req_record_count;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_ascii_char;
   logic                 rsp_run_last;
   logic                 rsp_error;

   record_text_model model;
   bit               steady;          // suppress idling on both sides
   int               items_accepted;

   hex_record_encoder_top u_top (.*);

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Sample every handshake at the rising edge; inputs only move on the
   // falling edge, so the values seen here are stable.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en) begin
            model.write_reg(csr_index, csr_wdata);
         end
         if (req_valid && !req_stall) begin
            model.encode_item(req_kind, req_data_byte, req_record_count);
            items_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            model.match_char(rsp_ascii_char, rsp_run_last, rsp_error);
         end
      end
   end

   // idle cycles before the next item on either side; at least a third are zero
   function automatic int pick_wait();
      if (steady || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // mostly short records, some medium, a few near the 8-bit limit
   function automatic logic [7:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         return 8'd0;
      end else if (r < 8) begin
         return 8'($urandom_range(200, 255));
      end else if (r < 30) begin
         return 8'($urandom_range(9, 40));
      end
      return 8'($urandom_range(1, 8));
   endfunction

   // Character sink: stall for a random number of cycles, then take one.
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         gap = pick_wait();
         @(negedge clock);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Present one item after a random gap and hold it until it is taken.
   // Valid is only lowered when a gap follows, never dropped and raised
   // in the same step.
   task automatic send_item(logic kind, logic [7:0] data, logic [7:0] count);
      int gap;
      gap = pick_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_data_byte    <= data;
      req_record_count <= count;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid, wait for every predicted character, then idle before returning.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (model.pending_chars.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // format write with junk in the unused upper bits
   task automatic set_format(logic [1:0] f);
      logic [31:0] val;
      val      = $urandom;
      val[1:0] = f;
      write_csr(CSR_FORMAT, val);
   endtask

   initial begin
      int          target;
      int          phase;
      int          nrec;
      int          full;
      int          n;
      logic [7:0]  count;
      logic [31:0] offset;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = CSR_FORMAT;
      csr_wdata        = 32'd0;
      req_valid        = 1'b0;
      req_kind         = 1'b0;
      req_data_byte    = 8'd0;
      req_record_count = 8'd0;
      steady           = 1'b0;
      items_accepted   = 0;
      model            = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed: S-records with the reset format and offset
      send_item(1'b0, 8'h00, 8'd1);       // record that opens and closes at once
      send_item(1'b0, 8'hFF, 8'd2);
      send_item(1'b0, 8'h5A, 8'hFF);      // count is ignored inside a record
      send_item(1'b0, 8'hA5, 8'd0);       // zero count acts as one, flagged
      send_item(1'b0, 8'h3C, 8'd255);     // count too long for S2, flagged
      send_item(1'b1, 8'hFF, 8'hFF);      // end record inside a record, flagged
      send_item(1'b1, 8'h00, 8'd0);       // clean end record

      // all-ones offset: S2 address wraps at 24 bits, S8 carries 0xFFFFFF
      settle();
      write_csr(CSR_OFFSET, 32'hFFFF_FFFF);
      send_item(1'b0, 8'h80, 8'd3);
      send_item(1'b0, 8'h01, 8'd0);
      send_item(1'b0, 8'h7F, 8'd128);
      send_item(1'b1, 8'h00, 8'd0);

      // Intel hex, then switch to Tek-hex while a record is open
      settle();
      set_format(FMT_INTEL);
      send_item(1'b0, 8'h12, 8'd2);
      send_item(1'b0, 8'hEF, 8'd0);
      send_item(1'b0, 8'hC3, 8'd252);
      settle();
      set_format(FMT_TEK);
      send_item(1'b0, 8'h96, 8'd1);
      send_item(1'b1, 8'h55, 8'hAA);

      // unused format code behaves as Tek-hex
      settle();
      set_format(FMT_UNUSED);
      send_item(1'b0, 8'hF0, 8'd2);
      send_item(1'b0, 8'h0F, 8'd7);
      send_item(1'b1, 8'h00, 8'd0);

      // plain Tek-hex with a zero offset
      settle();
      set_format(FMT_TEK);
      write_csr(CSR_OFFSET, 32'd0);
      send_item(1'b0, 8'hFF, 8'd1);
      send_item(1'b1, 8'h00, 8'd0);

      // ---- random record streams, one configuration per phase
      target = items_accepted + RANDOM_ITEMS;
      phase  = 0;
      while (items_accepted < target) begin
         settle();
         if (phase < 4) begin
            set_format(phase[1:0]);
         end else begin
            set_format(2'($urandom_range(0, 3)));
         end
         case ($urandom_range(0, 3))
            0:       offset = 32'd0;
            1:       offset = 32'hFFFF_FFFF;
            2:       offset = 32'h00FF_FFF0;
            default: offset = $urandom;
         endcase
         write_csr(CSR_OFFSET, offset);
         steady = (phase % 5 == 4);
         nrec   = $urandom_range(3, 10);
         for (int r = 0; (r < nrec) && (items_accepted < target); r++) begin
            // stray end record between records
            if ($urandom_range(0, 19) == 0) begin
               send_item(1'b1, 8'($urandom), 8'($urandom));
            end
            count = pick_count();
            full  = (count == 8'd0) ? 1 : int'(count);
            n     = full;
            // now and then cut the record short with an end record
            if ($urandom_range(0, 9) == 0) begin
               n = $urandom_range(1, full);
            end
            for (int i = 0; i < n; i++) begin
               send_item(1'b0, 8'($urandom), (i == 0) ? count : 8'($urandom));
            end
            if (n < full) begin
               send_item(1'b1, 8'($urandom), 8'($urandom));
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            send_item(1'b1, 8'($urandom), 8'($urandom));
         end
         phase++;
      end

      // ---- drain and report
      steady = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (model.pending_chars.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (model.mismatches == 0 && model.pending_chars.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d characters missing",
                  model.mismatches, model.pending_chars.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
